/* hdl/dcdu_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the DMA channel descriptor unit.
package dcdu_pkg;

	// Width of the channel number on the request channel.
	localparam int unsigned CHANNEL_W = 3;

	// Flag positions within the upper half of the control word.
	localparam int unsigned FLAG_ENABLE_BIT = 15;
	localparam int unsigned FLAG_REPEAT_BIT = 9;
	localparam int unsigned FLAG_32BIT_BIT  = 10;

	// Start modes, held in bits 13:12 of the upper half.
	localparam logic [1:0] START_NOW    = 2'b00;
	localparam logic [1:0] START_VBLANK = 2'b01;
	localparam logic [1:0] START_HBLANK = 2'b10;

	// Step modes for source (bits 8:7) and destination (bits 6:5).
	localparam logic [1:0] STEP_DEC    = 2'b01;
	localparam logic [1:0] STEP_FIXED  = 2'b10;
	localparam logic [1:0] STEP_RELOAD = 2'b11;

	// A stop clears start mode, request, repeat and enable.
	localparam logic [31:0] STOP_CLEAR_MASK = 32'hBA00_0000;

	// Unit counts used when the count field is zero.
	localparam logic [16:0] COUNT_ZERO_DEFAULT = 17'h0_4000;
	localparam logic [16:0] COUNT_ZERO_LAST_CH = 17'h1_0000;

	// Channel whose zero count means the full 64K units.
	localparam int unsigned LONG_CHANNEL = 3;

	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_STOP   = 2'd1,
		CMD_HBLANK = 2'd2,
		CMD_VBLANK = 2'd3
	} dcmd_t;

	// One request item.
	typedef struct packed {
		dcmd_t                 cmd;
		logic [CHANNEL_W-1:0]  channel;
		logic [31:0]           src_address;
		logic [31:0]           dest_address;
		logic [31:0]           control_word;
	} req_t;

	// One planned transfer.
	typedef struct packed {
		logic [1:0]         out_channel;
		logic [31:0]        start_src;
		logic [31:0]        start_dest;
		logic signed [3:0]  src_stride;
		logic signed [3:0]  dest_stride;
		logic [2:0]         unit_bytes;
		logic [16:0]        unit_count;
		logic [31:0]        end_src;
		logic [31:0]        end_dest;
		logic [31:0]        end_control;
		logic               last;
	} plan_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                  set_we;
		logic                  stop_we;
		logic                  fire;
		logic                  fire_last;
		logic [CHANNEL_W-1:0]  fire_idx;
	} dp_cmd_t;

endpackage

/* hdl/dcdu_datapath.sv */
`timescale 1ns / 1ps
// Register file, plan arithmetic and output register of the descriptor unit.
module dcdu_datapath #(
	parameter int unsigned CHANNELS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dcdu_pkg::req_t          req,
	input  dcdu_pkg::dp_cmd_t       cmd,
	output logic [CHANNELS-1:0]     mask_next,
	output dcdu_pkg::plan_t         plan
);
	import dcdu_pkg::*;

	localparam int unsigned CW = $clog2(CHANNELS);

	logic [31:0] src_q  [CHANNELS];
	logic [31:0] dest_q [CHANNELS];
	logic [31:0] ctl_q  [CHANNELS];
	plan_t       plan_q;

	logic [CW-1:0] wr_idx;
	logic [CW-1:0] pl_idx;
	logic [15:0]   req_hi;
	logic [1:0]    trig_mode;

	logic [31:0] s0, d0, ctl, ctl_end, s1, d1;
	logic [15:0] hi;
	logic        unit4;
	logic [16:0] count;
	logic [18:0] delta;
	logic [3:0]  step_pos, step_neg;
	plan_t       plan_d;

	assign wr_idx    = req.channel[CW-1:0];
	assign pl_idx    = cmd.fire_idx[CW-1:0];
	assign req_hi    = req.control_word[31:16];
	assign trig_mode = (req.cmd == CMD_HBLANK) ? START_HBLANK : START_VBLANK;

	// Channels that the accepted item will plan, lowest first.
	always_comb begin
		mask_next = '0;
		unique case (req.cmd)
			CMD_SET: begin
				if (cmd.set_we && req_hi[FLAG_ENABLE_BIT] && req_hi[13:12] == START_NOW) begin
					mask_next[wr_idx] = 1'b1;
				end
			end
			CMD_HBLANK, CMD_VBLANK: begin
				for (int i = 0; i < CHANNELS; i++) begin
					mask_next[i] = ctl_q[i][16 + FLAG_ENABLE_BIT] &&
						ctl_q[i][29:28] == trig_mode;
				end
			end
			default: begin
				mask_next = '0;
			end
		endcase
	end

	// Plan arithmetic for the selected channel.
	always_comb begin
		s0       = src_q[pl_idx];
		d0       = dest_q[pl_idx];
		ctl      = ctl_q[pl_idx];
		hi       = ctl[31:16];
		unit4    = hi[FLAG_32BIT_BIT];
		step_pos = unit4 ? 4'sd4 : 4'sd2;
		step_neg = unit4 ? 4'b1100 : 4'b1110;
		if (ctl[15:0] == 16'd0) begin
			count = (pl_idx == CW'(LONG_CHANNEL)) ? COUNT_ZERO_LAST_CH : COUNT_ZERO_DEFAULT;
		end else begin
			count = {1'b0, ctl[15:0]};
		end
		delta = unit4 ? {count, 2'b00} : {1'b0, count, 1'b0};

		plan_d = '0;
		case (hi[8:7])
			STEP_DEC: begin
				s1                = s0 - 32'(delta);
				plan_d.src_stride = step_neg;
			end
			STEP_FIXED: begin
				s1                = s0;
				plan_d.src_stride = 4'sd0;
			end
			default: begin
				s1                = s0 + 32'(delta);
				plan_d.src_stride = step_pos;
			end
		endcase
		case (hi[6:5])
			STEP_DEC: begin
				d1                 = d0 - 32'(delta);
				plan_d.dest_stride = step_neg;
			end
			STEP_FIXED: begin
				d1                 = d0;
				plan_d.dest_stride = 4'sd0;
			end
			STEP_RELOAD: begin
				d1                 = d0;
				plan_d.dest_stride = step_pos;
			end
			default: begin
				d1                 = d0 + 32'(delta);
				plan_d.dest_stride = step_pos;
			end
		endcase

		// Enable survives only for a repeating, triggered channel.
		ctl_end = ctl;
		if (!hi[FLAG_REPEAT_BIT] || hi[13:12] == START_NOW) begin
			ctl_end[16 + FLAG_ENABLE_BIT] = 1'b0;
		end

		plan_d.out_channel = 2'(pl_idx);
		plan_d.start_src   = s0;
		plan_d.start_dest  = d0;
		plan_d.unit_bytes  = unit4 ? 3'd4 : 3'd2;
		plan_d.unit_count  = count;
		plan_d.end_src     = s1;
		plan_d.end_dest    = d1;
		plan_d.end_control = ctl_end;
		plan_d.last        = cmd.fire_last;
	end

	// Channel register file: set, stop and plan write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				src_q[i]  <= '0;
				dest_q[i] <= '0;
				ctl_q[i]  <= '0;
			end
		end else begin
			if (cmd.set_we) begin
				src_q[wr_idx]  <= req.src_address;
				dest_q[wr_idx] <= req.dest_address;
				ctl_q[wr_idx]  <= req.control_word;
			end
			if (cmd.stop_we) begin
				ctl_q[wr_idx] <= ctl_q[wr_idx] & ~STOP_CLEAR_MASK;
			end
			if (cmd.fire) begin
				src_q[pl_idx]  <= s1;
				dest_q[pl_idx] <= d1;
				ctl_q[pl_idx]  <= ctl_end;
			end
		end
	end

	// Output register, loaded with each planned transfer.
	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			plan_q <= plan_d;
		end
	end

	assign plan = plan_q;

endmodule

/* hdl/dcdu_ctrl.sv */
`timescale 1ns / 1ps
// Controller: request handshake, channel scan sequencing and output valid.
module dcdu_ctrl #(
	parameter int unsigned CHANNELS = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  dcdu_pkg::dcmd_t           req_cmd,
	input  logic [dcdu_pkg::CHANNEL_W-1:0] req_channel,
	input  logic [CHANNELS-1:0]       mask_next,
	output dcdu_pkg::dp_cmd_t         cmd,
	output logic                      plan_valid,
	input  logic                      plan_stall
);
	import dcdu_pkg::*;

	localparam int unsigned CW = $clog2(CHANNELS);

	typedef enum logic {
		ST_IDLE,
		ST_PLAN
	} state_t;

	state_t              state_q;
	logic [CHANNELS-1:0] mask_q;
	logic [CHANNELS-1:0] rest;
	logic                plan_valid_q;
	logic [CW-1:0]       sel;
	logic                accept;
	logic                chan_ok;
	logic                fire;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign chan_ok   = {1'b0, req_channel} < (CHANNEL_W + 1)'(CHANNELS);

	// Lowest pending channel and what is left after it.
	always_comb begin
		sel = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = CW'(i);
			end
		end
	end
	assign rest = mask_q & (mask_q - CHANNELS'(1));

	// While planning, a plan is issued whenever the output register is free or being emptied.
	assign fire = (state_q == ST_PLAN) && (!plan_valid_q || !plan_stall);

	assign cmd.set_we    = accept && req_cmd == CMD_SET && chan_ok;
	assign cmd.stop_we   = accept && req_cmd == CMD_STOP && chan_ok;
	assign cmd.fire      = fire;
	assign cmd.fire_last = (rest == '0);
	assign cmd.fire_idx  = CHANNEL_W'(sel);

	// State, pending channel mask and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mask_q       <= '0;
			plan_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mask_q <= mask_next;
						if (mask_next != '0) begin
							state_q <= ST_PLAN;
						end
					end
				end
				ST_PLAN: begin
					if (fire) begin
						mask_q <= rest;
						if (rest == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				plan_valid_q <= 1'b1;
			end else if (!plan_stall) begin
				plan_valid_q <= 1'b0;
			end
		end
	end

	assign plan_valid = plan_valid_q;

endmodule

/* hdl/dma_channel_descriptor_unit_core.sv */
`timescale 1ns / 1ps
// Top level of the DMA channel descriptor unit.
//
// The request channel (req_valid, req_stall, req) carries set, stop, hblank
// and vblank commands. The plan channel (plan_valid, plan_stall, plan) gives
// one item per planned transfer, with last marking the final plan of a request.
// A set or stop is written to the channel registers at the edge of its
// transfer. A set that starts immediately, or a trigger, then plans each
// channel it selects: the request loads the pending channel mask, and the
// plans are then registered in the output register in turn, at most
// CHANNELS plans for one request. The channel scan is set by the single
// plan unit, which handles one channel register set per cycle in channel
// order while the output register is not stalled.
// The request side is held off (req_stall high) while plans remain; the last
// plan may still wait in the output register while the next request is taken.
// While plan_stall holds a valid plan in the output register, the scan
// waits. Reset clears all channel registers to zero and empties the output.
module dma_channel_descriptor_unit_core #(
	parameter int unsigned CHANNELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  dcdu_pkg::req_t    req,
	output logic              plan_valid,
	input  logic              plan_stall,
	output dcdu_pkg::plan_t   plan
);
	import dcdu_pkg::*;

	dp_cmd_t             cmd;
	logic [CHANNELS-1:0] mask_next;

	dcdu_ctrl #(
		.CHANNELS(CHANNELS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_cmd    (req.cmd),
		.req_channel(req.channel),
		.mask_next  (mask_next),
		.cmd        (cmd),
		.plan_valid (plan_valid),
		.plan_stall (plan_stall)
	);

	dcdu_datapath #(
		.CHANNELS(CHANNELS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.mask_next(mask_next),
		.plan     (plan)
	);

endmodule

/* hdl/dcdu_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the descriptor unit and its bind to the top level.
module dcdu_checker #(
	parameter int unsigned CHANNELS = 4
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input dcdu_pkg::req_t    req,
	input logic              plan_valid,
	input logic              plan_stall,
	input dcdu_pkg::plan_t   plan
);
	import dcdu_pkg::*;

	// A stalled plan holds until its transfer.
	a_plan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid && plan_stall |=> plan_valid && $stable(plan))
		else $error("plan changed while stalled");

	// A stop never produces a plan, so the unit is free again at once.
	a_stop_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.cmd == CMD_STOP |=> !req_stall && !$rose(plan_valid))
		else $error("stop command held the unit or raised a plan");

	// While plans of a request remain, requests are held off.
	a_hold_off: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid && !plan.last |-> req_stall)
		else $error("request taken before the last plan");

	// Once a non-final plan is taken, the next one follows in the next cycle.
	a_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid && !plan_stall && !plan.last |=> plan_valid)
		else $error("gap between plans of one request");

	// Unit size is two or four bytes.
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid |-> plan.unit_bytes == 3'd2 || plan.unit_bytes == 3'd4)
		else $error("bad unit size");

endmodule

bind dma_channel_descriptor_unit_core dcdu_checker #(.CHANNELS(CHANNELS)) u_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the DMA channel descriptor unit: directed and random requests.
module testbench;
	import dcdu_pkg::*;

	localparam int unsigned NCHAN       = 4;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 8;
	localparam int unsigned REPORT_CAP  = 100;

	// Field positions within the upper half of the control word.
	localparam int unsigned START_LSB = 12;
	localparam int unsigned SMODE_LSB = 7;
	localparam int unsigned DMODE_LSB = 5;

	// Codes that the package leaves unnamed.
	localparam logic [1:0] STEP_INC    = 2'b00;
	localparam logic [1:0] START_NEVER = 2'b11;

	logic  clk;
	logic  arst_n     = 1'b0;
	logic  req_valid  = 1'b0;
	logic  req_stall;
	req_t  req        = '0;
	logic  plan_valid;
	logic  plan_stall = 1'b0;
	plan_t plan;

	// Shadow copy of the channel register file.
	logic [31:0] chan_src [NCHAN];
	logic [31:0] chan_dest[NCHAN];
	logic [31:0] chan_ctl [NCHAN];

	// Plans still to come out of the block, oldest first.
	plan_t pending_plans[$];

	int unsigned send_idle_pct  = 19;
	int unsigned recv_stall_pct = 72;
	int unsigned error_count    = 0;
	int unsigned quiet_cycles   = 0;

	dma_channel_descriptor_unit_core #(
		.CHANNELS(NCHAN)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.plan_valid(plan_valid),
		.plan_stall(plan_stall),
		.plan      (plan)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Signed byte step for one address, from its two mode bits.
	function automatic int step_bytes(input logic [1:0] mode, input int unit);
		case (mode)
			STEP_DEC:   return -unit;
			STEP_FIXED: return 0;
			default:    return unit;
		endcase
	endfunction

	// Works out the transfer of one channel and writes the final registers back.
	function automatic plan_t plan_channel(input int unsigned ch);
		plan_t       p;
		logic [31:0] ctl;
		logic [15:0] hi;
		int          unit;
		int          count;
		int          sstep;
		int          dstep;
		ctl   = chan_ctl[ch];
		hi    = ctl[31:16];
		unit  = hi[FLAG_32BIT_BIT] ? 4 : 2;
		count = ctl[15:0];
		if (count == 0) begin
			count = (ch == LONG_CHANNEL) ? COUNT_ZERO_LAST_CH : COUNT_ZERO_DEFAULT;
		end
		sstep = step_bytes(hi[SMODE_LSB +: 2], unit);
		dstep = step_bytes(hi[DMODE_LSB +: 2], unit);
		p.out_channel = 2'(ch);
		p.start_src   = chan_src[ch];
		p.start_dest  = chan_dest[ch];
		p.src_stride  = 4'(sstep);
		p.dest_stride = 4'(dstep);
		p.unit_bytes  = 3'(unit);
		p.unit_count  = 17'(count);
		p.end_src     = chan_src[ch] + 32'(count * sstep);
		if (hi[DMODE_LSB +: 2] == STEP_RELOAD) begin
			p.end_dest = chan_dest[ch];
		end else begin
			p.end_dest = chan_dest[ch] + 32'(count * dstep);
		end
		// Enable survives only for a repeating channel on a blanking trigger.
		if (!hi[FLAG_REPEAT_BIT] || hi[START_LSB +: 2] == START_NOW) begin
			ctl[16 + FLAG_ENABLE_BIT] = 1'b0;
		end
		p.end_control = ctl;
		p.last        = 1'b0;
		chan_src[ch]  = p.end_src;
		chan_dest[ch] = p.end_dest;
		chan_ctl[ch]  = ctl;
		return p;
	endfunction

	// Updates the shadow registers for one request and queues the plans it causes.
	function automatic void predict_request(input req_t r);
		plan_t      burst[$];
		logic [1:0] mode;
		case (r.cmd)
			CMD_SET: begin
				if (r.channel < NCHAN) begin
					chan_src[r.channel]  = r.src_address;
					chan_dest[r.channel] = r.dest_address;
					chan_ctl[r.channel]  = r.control_word;
					if (r.control_word[16 + FLAG_ENABLE_BIT] &&
						r.control_word[16 + START_LSB +: 2] == START_NOW) begin
						burst.push_back(plan_channel(r.channel));
					end
				end
			end
			CMD_STOP: begin
				if (r.channel < NCHAN) begin
					chan_ctl[r.channel] = chan_ctl[r.channel] & ~STOP_CLEAR_MASK;
				end
			end
			default: begin
				mode = (r.cmd == CMD_HBLANK) ? START_HBLANK : START_VBLANK;
				for (int unsigned i = 0; i < NCHAN; i++) begin
					if (chan_ctl[i][16 + FLAG_ENABLE_BIT] &&
						chan_ctl[i][16 + START_LSB +: 2] == mode) begin
						burst.push_back(plan_channel(i));
					end
				end
			end
		endcase
		if (burst.size() > 0) begin
			burst[burst.size() - 1].last = 1'b1;
		end
		foreach (burst[i]) begin
			pending_plans.push_back(burst[i]);
		end
	endfunction

	// Upper half of a control word, built from its fields.
	function automatic logic [15:0] ctl_flags(input bit en, input logic [1:0] start,
			input bit rep, input bit wide, input logic [1:0] smode, input logic [1:0] dmode);
		logic [15:0] f;
		f = '0;
		f[FLAG_ENABLE_BIT]    = en;
		f[START_LSB +: 2]     = start;
		f[FLAG_REPEAT_BIT]    = rep;
		f[FLAG_32BIT_BIT]     = wide;
		f[SMODE_LSB +: 2]     = smode;
		f[DMODE_LSB +: 2]     = dmode;
		return f;
	endfunction

	function automatic req_t set_request(input int unsigned ch, input logic [31:0] src,
			input logic [31:0] dst, input logic [15:0] hi, input logic [15:0] cnt);
		req_t r;
		r.cmd          = CMD_SET;
		r.channel      = CHANNEL_W'(ch);
		r.src_address  = src;
		r.dest_address = dst;
		r.control_word = {hi, cnt};
		return r;
	endfunction

	// A stop or trigger; the unused fields carry random content.
	function automatic req_t bare_request(input dcmd_t cmd, input int unsigned ch);
		req_t r;
		r.cmd          = cmd;
		r.channel      = CHANNEL_W'(ch);
		r.src_address  = $urandom;
		r.dest_address = $urandom;
		r.control_word = $urandom;
		return r;
	endfunction

	// Mostly well-formed traffic on valid channels, with some noise on any channel.
	function automatic req_t random_request();
		req_t        r;
		logic [15:0] hi;
		logic [15:0] cnt;
		int unsigned pick;
		pick = $urandom_range(99);
		hi   = 16'($urandom);
		hi[FLAG_ENABLE_BIT] = ($urandom_range(3) != 0);
		cnt  = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
		r.src_address  = $urandom;
		r.dest_address = $urandom;
		r.control_word = {hi, cnt};
		r.channel      = CHANNEL_W'($urandom_range(NCHAN - 1));
		if (pick < 45) begin
			r.cmd = CMD_SET;
		end else if (pick < 55) begin
			r.cmd = CMD_STOP;
		end else if (pick < 72) begin
			r.cmd = CMD_HBLANK;
		end else if (pick < 90) begin
			r.cmd = CMD_VBLANK;
		end else begin
			r.cmd     = dcmd_t'($urandom_range(3));
			r.channel = CHANNEL_W'($urandom_range(7));
		end
		return r;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < REPORT_CAP) begin
			$display("%0t: mismatch in %s: got 0x%h, expected 0x%h", $time, what, got, want);
		end
		error_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	// Presents one request and holds it until its transfer.
	task automatic send_request(input req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		predict_request(r);
		req       = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// Holds the request side idle until every expected plan has come out.
	task automatic hold_until_drained();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_plans.size() != 0) @(posedge clk);
	endtask

	// Immediate starts: unit sizes, all step modes, zero counts and address extremes.
	task automatic test_immediate_sets();
		send_request(set_request(0, 32'h0000_0000, 32'hFFFF_FFFF,
			ctl_flags(1, START_NOW, 0, 1, STEP_INC, STEP_DEC), 16'h0000));
		send_request(set_request(3, 32'hFFFF_FFFF, 32'h0000_0000,
			ctl_flags(1, START_NOW, 1, 0, STEP_DEC, STEP_FIXED), 16'h0000));
		send_request(set_request(1, 32'h0000_0002, 32'h8000_0000,
			ctl_flags(1, START_NOW, 0, 1, STEP_FIXED, STEP_RELOAD), 16'hFFFF));
		send_request(set_request(2, 32'h7FFF_FFFE, 32'h0000_0010,
			ctl_flags(1, START_NOW, 0, 0, STEP_RELOAD, STEP_INC), 16'h0001));
		// A disabled channel is only stored.
		send_request(set_request(2, $urandom, $urandom,
			ctl_flags(0, START_NOW, 1, 1, STEP_DEC, STEP_DEC), 16'h0004));
		// All flags set: the special start mode never plans.
		send_request(set_request(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
	endtask

	// Blanking triggers: matching, repeat, one-shot and the special start mode.
	task automatic test_triggers();
		send_request(set_request(0, $urandom, $urandom,
			ctl_flags(1, START_HBLANK, 1, 1, STEP_DEC, STEP_INC), 16'h0005));
		send_request(set_request(1, $urandom, $urandom,
			ctl_flags(1, START_VBLANK, 0, 0, STEP_INC, STEP_DEC), 16'h0100));
		send_request(set_request(2, $urandom, $urandom,
			ctl_flags(1, START_HBLANK, 0, 1, STEP_INC, STEP_RELOAD), 16'h0003));
		send_request(set_request(3, $urandom, $urandom,
			ctl_flags(1, START_NEVER, 1, 1, STEP_INC, STEP_INC), 16'h0007));
		send_request(bare_request(CMD_HBLANK, 0));
		send_request(bare_request(CMD_HBLANK, 5));
		send_request(bare_request(CMD_VBLANK, 2));
		// Nothing is left armed for vertical blank.
		send_request(bare_request(CMD_VBLANK, 7));
	endtask

	// Stops, and sets and stops on channels beyond the last one.
	task automatic test_stop_and_ignored();
		send_request(bare_request(CMD_STOP, 0));
		send_request(bare_request(CMD_HBLANK, 1));
		send_request(set_request(4, $urandom, $urandom,
			ctl_flags(1, START_NOW, 0, 1, STEP_INC, STEP_INC), 16'h0002));
		send_request(set_request(7, $urandom, $urandom, 16'hFFFF, 16'h0000));
		send_request(bare_request(CMD_STOP, 5));
		send_request(bare_request(CMD_STOP, 3));
	endtask

	// Every channel armed for vertical blank, so one trigger plans four transfers.
	task automatic test_full_scan();
		for (int unsigned ch = 0; ch < NCHAN; ch++) begin
			send_request(set_request(ch, $urandom, $urandom,
				ctl_flags(1, START_VBLANK, 1, ch[0], 2'(ch), 2'(3 - ch)),
				(ch == LONG_CHANNEL) ? 16'h0000 : 16'($urandom)));
		end
		send_request(bare_request(CMD_VBLANK, 0));
		send_request(bare_request(CMD_VBLANK, 4));
	endtask

	// Random traffic under one idling profile, then a pause until the block is empty.
	task automatic test_random_traffic(input int unsigned n_items,
			input int unsigned send_pct, input int unsigned stall_pct);
		req_t        r;
		int unsigned n_done;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		n_done         = 0;
		while (n_done < n_items) begin
			r = random_request();
			send_request(r);
			if (!((r.cmd == CMD_SET || r.cmd == CMD_STOP) && r.channel >= NCHAN)) begin
				n_done++;
			end
		end
		hold_until_drained();
	endtask

	// Receiver back-pressure, changed at the falling edge.
	always @(negedge clk) begin
		plan_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Compares each plan transfer with the oldest expected plan.
	always @(posedge clk) begin
		plan_t want;
		if (arst_n && plan_valid && !plan_stall) begin
			if (pending_plans.size() == 0) begin
				report_mismatch("unexpected plan, start_src", plan.start_src, '0);
			end else begin
				want = pending_plans.pop_front();
				check_field("out_channel", plan.out_channel, want.out_channel);
				check_field("start_src",   plan.start_src,   want.start_src);
				check_field("start_dest",  plan.start_dest,  want.start_dest);
				check_field("src_stride",  plan.src_stride,  want.src_stride);
				check_field("dest_stride", plan.dest_stride, want.dest_stride);
				check_field("unit_bytes",  plan.unit_bytes,  want.unit_bytes);
				check_field("unit_count",  plan.unit_count,  want.unit_count);
				check_field("end_src",     plan.end_src,     want.end_src);
				check_field("end_dest",    plan.end_dest,    want.end_dest);
				check_field("end_control", plan.end_control, want.end_control);
				check_field("last",        plan.last,        want.last);
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (plan_valid && !plan_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		for (int unsigned i = 0; i < NCHAN; i++) begin
			chan_src[i]  = '0;
			chan_dest[i] = '0;
			chan_ctl[i]  = '0;
		end
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_immediate_sets();
		test_triggers();
		test_stop_and_ignored();
		test_full_scan();
		hold_until_drained();
		test_random_traffic(90, 19, 72);
		test_random_traffic(90, 72, 19);
		test_random_traffic(90, 0, 0);

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_plans.size() != 0) begin
			report_mismatch("plans left over", pending_plans.size(), 0);
		end
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
